@@ sv/rne_pkg.sv @@
// Shared types, constants and symbol decode for the Roman numeral encoder.
package rne_pkg;

	localparam int unsigned VALUE_W = 12;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned POS_W   = 2;
	localparam int unsigned LEN_W   = 3;
	localparam int unsigned MULT_W  = 14;

	localparam logic [VALUE_W-1:0] VALUE_MAX_VALID = 12'd3999;

	localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
	localparam logic [CHAR_W-1:0] CH_I    = 7'h49;
	localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
	localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
	localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
	localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
	localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
	localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;

	localparam logic [POS_W-1:0] POS_ONES      = 2'd0;
	localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

	// unit, five and ten symbol of each decimal place, ones first
	localparam logic [CHAR_W-1:0] UNIT_SYM [4] = '{CH_I, CH_X, CH_C, CH_M};
	localparam logic [CHAR_W-1:0] FIVE_SYM [4] = '{CH_V, CH_L, CH_D, CH_NONE};
	localparam logic [CHAR_W-1:0] TEN_SYM  [4] = '{CH_X, CH_C, CH_M, CH_NONE};

	// multiples of each place value, digit 0 to 9
	localparam logic [MULT_W-1:0] PLACE_MULT [4][10] = '{
		'{14'd0, 14'd1,    14'd2,    14'd3,    14'd4,
		  14'd5, 14'd6,    14'd7,    14'd8,    14'd9},
		'{14'd0, 14'd10,   14'd20,   14'd30,   14'd40,
		  14'd50, 14'd60,  14'd70,   14'd80,   14'd90},
		'{14'd0, 14'd100,  14'd200,  14'd300,  14'd400,
		  14'd500, 14'd600, 14'd700, 14'd800,  14'd900},
		'{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
		  14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000}
	};

	typedef struct packed {
		logic load;      // capture the input value
		logic emit_err;  // write the out-of-range beat
		logic extract;   // find the digit of the current place
		logic emit;      // write the next symbol beat
		logic next_pos;  // step down to the next place
	} cmd_t;

	typedef struct packed {
		logic bad;        // captured value is zero or above the valid range
		logic len_zero;   // current digit writes no symbol
		logic sym_done;   // current symbol is the digit's last
		logic last;       // current symbol is the numeral's last
		logic pos_ones;   // current place is the ones
		logic slot_free;  // output register can take a beat
	} status_t;

	function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
		logic [LEN_W-1:0] len;
		if (d == 4'd9 || d == 4'd4) begin
			len = 3'd2;
		end else if (d >= 4'd5) begin
			len = LEN_W'(d - 4'd4);
		end else begin
			len = LEN_W'(d);
		end
		return len;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_sym(input logic [POS_W-1:0] pos,
			input logic [DIGIT_W-1:0] d, input logic [1:0] k);
		logic [CHAR_W-1:0] sym;
		if (d == 4'd9) begin
			sym = (k == 2'd0) ? UNIT_SYM[pos] : TEN_SYM[pos];
		end else if (d == 4'd4) begin
			sym = (k == 2'd0) ? UNIT_SYM[pos] : FIVE_SYM[pos];
		end else if (d >= 4'd5) begin
			sym = (k == 2'd0) ? FIVE_SYM[pos] : UNIT_SYM[pos];
		end else begin
			sym = UNIT_SYM[pos];
		end
		return sym;
	endfunction

endpackage

@@ sv/rne_if.sv @@
// Valid/ready stream interfaces for the encoder's input value and symbol beats.
interface rne_value_if;
	logic        valid;
	logic        ready;
	logic [11:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface rne_symbol_if;
	logic       valid;
	logic       ready;
	logic [6:0] symbol_char;
	logic       last_symbol;
	logic       out_of_range;

	modport source (output valid, output symbol_char, output last_symbol,
		output out_of_range, input ready);
	modport sink (input valid, input symbol_char, input last_symbol,
		input out_of_range, output ready);
endinterface

@@ sv/rne_datapath.sv @@
// Datapath: remainder, digit extraction, symbol counters and output register.
module rne_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rne_pkg::cmd_t                  cmd,
	input  logic [rne_pkg::VALUE_W-1:0]    value,
	output rne_pkg::status_t               st,
	rne_symbol_if.source                   symbols
);

	logic [rne_pkg::VALUE_W-1:0] rem_q;
	logic [rne_pkg::DIGIT_W-1:0] digit_q;
	logic [rne_pkg::POS_W-1:0]   pos_q;
	logic [1:0]                  k_q;

	logic                        out_valid_q;
	logic [rne_pkg::CHAR_W-1:0]  sym_q;
	logic                        last_q;
	logic                        oor_q;

	logic [rne_pkg::DIGIT_W-1:0] digit_d;
	logic [rne_pkg::MULT_W-1:0]  rem_ext;
	logic [rne_pkg::MULT_W-1:0]  rem_next;
	logic [rne_pkg::LEN_W-1:0]   len;
	logic                        rem_zero;

	// largest digit whose multiple of the place still fits in the remainder
	always_comb begin
		rem_ext = {2'b00, rem_q};
		digit_d = '0;
		for (int j = 1; j < 10; j++) begin
			if (rem_ext >= rne_pkg::PLACE_MULT[pos_q][j]) begin
				digit_d = rne_pkg::DIGIT_W'(j);
			end
		end
		rem_next = rem_ext - rne_pkg::PLACE_MULT[pos_q][digit_d];
	end

	assign len      = rne_pkg::digit_len(digit_q);
	assign rem_zero = (rem_q == '0);

	always_comb begin
		st.bad       = rem_zero || (rem_q > rne_pkg::VALUE_MAX_VALID);
		st.len_zero  = (len == '0);
		st.sym_done  = ({1'b0, k_q} == len - 3'd1);
		st.last      = st.sym_done && rem_zero;
		st.pos_ones  = (pos_q == rne_pkg::POS_ONES);
		st.slot_free = !out_valid_q || symbols.ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= value;
			pos_q <= rne_pkg::POS_THOUSANDS;
		end else begin
			if (cmd.extract) begin
				rem_q   <= rem_next[rne_pkg::VALUE_W-1:0];
				digit_q <= digit_d;
				k_q     <= '0;
			end
			if (cmd.emit) begin
				k_q <= k_q + 2'd1;
			end
			if (cmd.next_pos) begin
				pos_q <= pos_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (symbols.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			sym_q  <= rne_pkg::CH_NONE;
			last_q <= 1'b1;
			oor_q  <= 1'b1;
		end else if (cmd.emit) begin
			sym_q  <= rne_pkg::digit_sym(pos_q, digit_q, k_q);
			last_q <= st.last;
			oor_q  <= 1'b0;
		end
	end

	assign symbols.valid        = out_valid_q;
	assign symbols.symbol_char  = sym_q;
	assign symbols.last_symbol  = last_q;
	assign symbols.out_of_range = oor_q;

endmodule

@@ sv/rne_ctrl.sv @@
// Controller: sequences capture, range check, digit extraction and symbol beats.
module rne_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rne_pkg::status_t st,
	output rne_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_EXTRACT,
		S_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_CHECK: begin
				cmd.emit_err = st.bad && st.slot_free;
			end
			S_EXTRACT: begin
				cmd.extract = 1'b1;
			end
			S_EMIT: begin
				if (st.len_zero) begin
					cmd.next_pos = 1'b1;
				end else if (st.slot_free) begin
					cmd.emit     = 1'b1;
					cmd.next_pos = st.sym_done;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!st.bad) begin
						state_q <= S_EXTRACT;
					end else if (st.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EXTRACT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// skip an empty place, finish on the numeral's last symbol
					if (st.len_zero) begin
						state_q <= st.pos_ones ? S_IDLE : S_EXTRACT;
					end else if (st.slot_free && st.sym_done) begin
						state_q <= (st.last || st.pos_ones) ? S_IDLE : S_EXTRACT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/roman_numeral_encoder_core.sv @@
// Top level of the Roman numeral encoder: controller plus datapath.
//
//  channel   role   payload                                       beats per item
//  numbers   sink   value[11:0]                                   1
//  symbols   source symbol_char[6:0], last_symbol, out_of_range   1 to 15
//
// An item first passes through capture and range check, which is all an out-of-range
// value needs. A valid one then takes, for each decimal place from thousands down
// to the last nonzero one, an extraction step followed by its symbols one by one,
// or by a skip step for an empty place.
// arst_n clears the controller and the output valid flag; nothing else is kept.
// A stalled symbols channel holds the current beat and pauses the sequence.
module roman_numeral_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	rne_value_if.sink   numbers,
	rne_symbol_if.source symbols
);

	rne_pkg::cmd_t    cmd;
	rne_pkg::status_t st;

	rne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (numbers.valid),
		.in_ready (numbers.ready),
		.st       (st),
		.cmd      (cmd)
	);

	rne_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.value   (numbers.value),
		.st      (st),
		.symbols (symbols)
	);

endmodule

@@ sim/numeral_check.sv @@
`timescale 1ns / 1ps
// Watches both encoder channels, predicts each numeral's symbol beats and compares them.
module numeral_check (
	input  logic         clk,
	input  logic         arst_n,
	rne_value_if         numbers,
	rne_symbol_if        symbols,
	output int           fail_count,
	output int           pending,
	output int           values_seen,
	output int           beats_seen,
	output int           rejects_seen
);

	typedef struct packed {
		logic [rne_pkg::CHAR_W-1:0] ch;
		logic                       last;
		logic                       oor;
	} roman_beat_t;

	roman_beat_t expected_beats[$];

	function automatic void push_symbol(input logic [rne_pkg::CHAR_W-1:0] ch);
		roman_beat_t b;
		b.ch   = ch;
		b.last = 1'b0;
		b.oor  = 1'b0;
		expected_beats.push_back(b);
	endfunction

	// one decimal place: unit, five and ten symbol of that place
	function automatic void push_place(input int unsigned digit,
			input logic [rne_pkg::CHAR_W-1:0] one, input logic [rne_pkg::CHAR_W-1:0] five,
			input logic [rne_pkg::CHAR_W-1:0] ten);
		int unsigned rest;
		rest = digit;
		if (digit == 9) begin
			push_symbol(one);
			push_symbol(ten);
		end else if (digit == 4) begin
			push_symbol(one);
			push_symbol(five);
		end else begin
			if (rest >= 5) begin
				push_symbol(five);
				rest = rest - 5;
			end
			repeat (rest) push_symbol(one);
		end
	endfunction

	function automatic void predict_numeral(input logic [rne_pkg::VALUE_W-1:0] value);
		int unsigned v;
		roman_beat_t b;
		v = value;
		if (v == 0 || v > rne_pkg::VALUE_MAX_VALID) begin
			b.ch   = rne_pkg::CH_NONE;
			b.last = 1'b1;
			b.oor  = 1'b1;
			expected_beats.push_back(b);
			rejects_seen++;
		end else begin
			repeat (v / 1000) push_symbol(rne_pkg::CH_M);
			push_place((v / 100) % 10, rne_pkg::CH_C, rne_pkg::CH_D, rne_pkg::CH_M);
			push_place((v / 10) % 10, rne_pkg::CH_X, rne_pkg::CH_L, rne_pkg::CH_C);
			push_place(v % 10, rne_pkg::CH_I, rne_pkg::CH_V, rne_pkg::CH_X);
			expected_beats[expected_beats.size()-1].last = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		roman_beat_t want;
		int errs;
		if (!arst_n) begin
			expected_beats.delete();
			fail_count   <= 0;
			pending      <= 0;
			values_seen  <= 0;
			beats_seen   <= 0;
			rejects_seen = 0;
		end else begin
			errs = 0;
			if (numbers.valid && numbers.ready) begin
				predict_numeral(numbers.value);
				values_seen <= values_seen + 1;
			end
			if (symbols.valid && symbols.ready) begin
				beats_seen <= beats_seen + 1;
				if (expected_beats.size() == 0) begin
					$error("unexpected symbol beat: char %h last %b oor %b",
						symbols.symbol_char, symbols.last_symbol, symbols.out_of_range);
					errs++;
				end else begin
					want = expected_beats.pop_front();
					if (symbols.symbol_char !== want.ch) begin
						$error("symbol_char: expected %h, got %h", want.ch, symbols.symbol_char);
						errs++;
					end
					if (symbols.last_symbol !== want.last) begin
						$error("last_symbol: expected %b, got %b",
							want.last, symbols.last_symbol);
						errs++;
					end
					if (symbols.out_of_range !== want.oor) begin
						$error("out_of_range: expected %b, got %b",
							want.oor, symbols.out_of_range);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending    <= expected_beats.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the encoder testbench: clock, reset, value stimulus, symbol back-pressure, verdict.
module testbench;

	localparam int RANDOM_VALUES = 200;
	localparam int CALM_TAIL     = 30;
	localparam int HOLD_CYCLES   = 80;
	localparam int HOLD_AFTER    = 60;

	logic clk;
	logic arst_n;

	int fail_count;
	int pending;
	int values_seen;
	int beats_seen;
	int rejects_seen;

	int values_sent;
	bit calm;
	bit hold_done;

	rne_value_if  numbers_ch ();
	rne_symbol_if symbols_ch ();

	roman_numeral_encoder_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.numbers (numbers_ch),
		.symbols (symbols_ch)
	);

	numeral_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.numbers      (numbers_ch),
		.symbols      (symbols_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.values_seen  (values_seen),
		.beats_seen   (beats_seen),
		.rejects_seen (rejects_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// offer one value and hold it until the block takes the beat
	task automatic send_value(input logic [rne_pkg::VALUE_W-1:0] v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			numbers_ch.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		numbers_ch.valid = 1'b1;
		numbers_ch.value = v;
		do @(posedge clk); while (!numbers_ch.ready);
		values_sent++;
		@(negedge clk);
	endtask

	// symbol side: short idle bursts, runs of ready, one long hold-off
	initial begin
		symbols_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!hold_done && values_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				symbols_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				symbols_ch.ready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end else begin
				symbols_ch.ready = 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	initial begin
		logic [rne_pkg::VALUE_W-1:0] directed [] = '{
			12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd10, 12'd14, 12'd40,
			12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd900, 12'd999,
			12'd1000, 12'd1994, 12'd3888, 12'd3999, 12'd0, 12'd4000, 12'd4095,
			12'd2730, 12'd1365
		};
		logic [rne_pkg::VALUE_W-1:0] v;
		int pick;

		values_sent      = 0;
		calm             = 1'b0;
		hold_done        = 1'b0;
		numbers_ch.valid = 1'b0;
		numbers_ch.value = '0;
		arst_n           = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_value(directed[i]);

		for (int n = 0; n < RANDOM_VALUES; n++) begin
			if (n >= RANDOM_VALUES - CALM_TAIL) calm = 1'b1;
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				v = $urandom_range(0, 1) ? rne_pkg::VALUE_W'(0) :
					rne_pkg::VALUE_W'($urandom_range(4000, 4095));
			end else if (pick < 5) begin
				v = rne_pkg::VALUE_W'($urandom_range(1, 99));
			end else begin
				v = rne_pkg::VALUE_W'($urandom_range(1, 3999));
			end
			send_value(v);
		end
		numbers_ch.valid = 1'b0;

		// drain, then give the block time to emit anything stray
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d values (%0d out of range) and %0d symbol beats",
			values_seen, rejects_seen, beats_seen);
		$display("idle bursts on both channels plus one long symbol-side hold-off");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
